// File: hdl/ucd_pkg.sv
// Package: shared types and state codes for the undirected cycle detector.
`timescale 1ns / 1ps
`default_nettype none
package ucd_pkg;

  typedef struct packed {
    logic       edge_present;
    logic [7:0] end_a;
    logic [7:0] end_b;
    logic       last_edge;
  } ucd_in_t;

  typedef struct packed {
    logic cycle_found;
    logic input_error;
  } ucd_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_FRAME,
    ST_SCAN,
    ST_MATCH,
    ST_POP,
    ST_DONE,
    ST_CLEAR
  } ucd_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_edge;
    logic root_next;
    logic root_push;
    logic frame_read;
    logic edge_read;
    logic scan_step;
    logic push_nb;
    logic pop;
    logic clear_step;
    logic clear_start;
    logic finish;
  } ucd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic root_end;
    logic root_visited;
    logic scan_end;
    logic nb_new;
    logic nb_cycle;
    logic stack_empty;
    logic clear_end;
  } ucd_sts_t;

endpackage
`default_nettype wire

// File: hdl/ucd_ctrl.sv
// Controller: sequences edge loading, the search walk and the visited clear.
`timescale 1ns / 1ps
`default_nettype none
module ucd_ctrl
  import ucd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     last_edge,
  input  wire ucd_sts_t sts,
  output ucd_cmd_t      cmd,
  output logic          busy,
  output logic          out_valid
);

  ucd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start && last_edge) state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sts.root_end)          state_nxt = ST_DONE;
        else if (!sts.root_visited) state_nxt = ST_FRAME;
      end
      ST_FRAME: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_end) state_nxt = ST_POP;
        else              state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        if (sts.nb_cycle)    state_nxt = ST_DONE;
        else if (sts.nb_new) state_nxt = ST_FRAME;
        else                 state_nxt = ST_SCAN;
      end
      ST_POP: begin
        if (sts.stack_empty) state_nxt = ST_ROOT;
        else                 state_nxt = ST_FRAME;
      end
      ST_DONE:  state_nxt = ST_CLEAR;
      ST_CLEAR: if (sts.clear_end) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy            = 1'b0;
        cmd.load_edge   = start;
        cmd.clear_start = start && last_edge;
      end
      ST_ROOT: begin
        cmd.root_push = !sts.root_end && !sts.root_visited;
        cmd.root_next = !sts.root_end && sts.root_visited;
      end
      ST_FRAME: cmd.frame_read = 1'b1;
      ST_SCAN:  cmd.edge_read  = !sts.scan_end;
      ST_MATCH: begin
        cmd.scan_step = 1'b1;
        cmd.push_nb   = sts.nb_new;
      end
      ST_POP:   cmd.pop = 1'b1;
      ST_DONE: begin
        out_valid  = 1'b1;
        cmd.finish = 1'b1;
      end
      ST_CLEAR: cmd.clear_step = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/ucd_dpath.sv
// Datapath: edge memory, frame stack, visited bits and the neighbor check.
`timescale 1ns / 1ps
`default_nettype none
module ucd_dpath
  import ucd_pkg::*;
#(
  parameter int MAX_EDGES = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ucd_in_t  in_data,
  input  wire logic [8:0] vcount,
  input  wire ucd_cmd_t cmd,
  output ucd_sts_t      sts,
  output ucd_out_t      result
);

  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW = $clog2(MAX_EDGES + 1);

  // edge memory
  logic [15:0] emem [MAX_EDGES];
  logic [15:0] erd_r;
  logic [TW-1:0] etotal_r;
  logic          err_r;

  // stack: vertex, parent, has_par, pos
  typedef struct packed {
    logic [7:0]    vert;
    logic [7:0]    par;
    logic          has_par;
    logic [TW-1:0] pos;
  } frame_t;
  frame_t smem [256];
  frame_t frm_r;
  logic [8:0] sp_r;

  logic [255:0] vis_r;
  logic [8:0]   root_r;
  logic [8:0]   clr_r;
  logic         cyc_r;

  logic [8:0] cnt;
  assign cnt = (vcount > 9'd256) ? 9'd256 : vcount;

  logic bad;
  assign bad = ({1'b0, in_data.end_a} >= cnt) || ({1'b0, in_data.end_b} >= cnt)
               || (etotal_r >= TW'(MAX_EDGES));

  logic [7:0] ea, eb, nb;
  logic hit;
  assign ea  = erd_r[15:8];
  assign eb  = erd_r[7:0];
  assign hit = (ea == frm_r.vert) || (eb == frm_r.vert);
  assign nb  = (ea == frm_r.vert) ? eb : ea;

  logic wr_stack;
  frame_t wr_frame;
  logic [7:0] wr_addr;
  always_comb begin
    wr_stack = 1'b0;
    wr_frame = frm_r;
    wr_addr  = 8'(sp_r - 9'd1);
    if (cmd.root_push) begin
      wr_stack = 1'b1;
      wr_frame = '{vert: root_r[7:0], par: 8'd0, has_par: 1'b0, pos: '0};
      wr_addr  = 8'd0;
    end else if (cmd.scan_step) begin
      wr_stack = 1'b1;
      wr_frame.pos = frm_r.pos + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge && in_data.edge_present && !bad)
      emem[etotal_r[EW-1:0]] <= {in_data.end_a, in_data.end_b};
    if (cmd.edge_read)
      erd_r <= emem[frm_r.pos[EW-1:0]];
    if (wr_stack)
      smem[wr_addr] <= wr_frame;
    if (cmd.push_nb && sp_r < 9'd256)
      smem[sp_r[7:0]] <= '{vert: nb, par: frm_r.vert, has_par: 1'b1, pos: '0};
    if (cmd.frame_read)
      frm_r <= smem[8'(sp_r - 9'd1)];
    else if (cmd.scan_step)
      frm_r.pos <= frm_r.pos + TW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etotal_r <= '0;
      err_r    <= 1'b0;
      vis_r    <= '0;
      sp_r     <= '0;
      root_r   <= '0;
      clr_r    <= '0;
      cyc_r    <= 1'b0;
    end else begin
      if (cmd.load_edge && in_data.edge_present) begin
        if (bad) err_r    <= 1'b1;
        else     etotal_r <= etotal_r + TW'(1);
      end
      if (cmd.clear_start) begin
        root_r <= '0;
        sp_r   <= '0;
        cyc_r  <= 1'b0;
      end
      if (cmd.root_next) root_r <= root_r + 9'd1;
      if (cmd.root_push) begin
        vis_r[root_r[7:0]] <= 1'b1;
        sp_r <= 9'd1;
        root_r <= root_r + 9'd1;
      end
      if (cmd.push_nb) begin
        vis_r[nb] <= 1'b1;
        sp_r      <= sp_r + 9'd1;
      end
      if (cmd.scan_step && sts.nb_cycle) cyc_r <= 1'b1;
      if (cmd.pop) sp_r <= sp_r - 9'd1;
      if (cmd.finish) begin
        etotal_r <= '0;
        err_r    <= 1'b0;
        clr_r    <= '0;
      end
      if (cmd.clear_step) begin
        vis_r[clr_r[7:0]] <= 1'b0;
        clr_r <= clr_r + 9'd1;
      end
    end
  end

  assign sts.root_end     = (root_r >= cnt);
  assign sts.root_visited = vis_r[root_r[7:0]];
  assign sts.scan_end     = (frm_r.pos >= etotal_r);
  assign sts.nb_new       = hit && !vis_r[nb] && (sp_r < 9'd256);
  assign sts.nb_cycle     = hit && vis_r[nb] && !(frm_r.has_par && nb == frm_r.par);
  assign sts.stack_empty  = (sp_r == 9'd1);
  assign sts.clear_end    = (clr_r == 9'd255);

  assign result.cycle_found = cyc_r;
  assign result.input_error = err_r;

endmodule
`default_nettype wire

// File: hdl/undirected_cycle_detect_top.sv
// Top level: undirected cycle detector, controller plus datapath.
//
//  channel  | ports                          | transfer
//  input    | start, busy, in_data           | start && !busy
//  result   | out_valid, out_data            | out_valid, one cycle
//  config   | cfg_we, cfg_data               | cfg_we
//
// Edges transfer back to back, one per cycle, while busy is low. The last edge starts
// the search, which checks each root vertex, loads or reloads a frame, reads and
// matches each stored edge scanned by a frame and retires the frame. Then a result
// strobe and a pass clearing all 256 visited bits. Reset is synchronous, active low.
// The receiver cannot stall; the result strobe lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none
module undirected_cycle_detect_top
  import ucd_pkg::*;
#(
  parameter int MAX_EDGES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire ucd_in_t    in_data,
  output logic            out_valid,
  output ucd_out_t        out_data,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_data
);

  logic [8:0] vcount_r;
  ucd_cmd_t cmd;
  ucd_sts_t sts;
  ucd_out_t res;

  always_ff @(posedge clk) begin
    if (!rst_n)      vcount_r <= 9'd256;
    else if (cfg_we) vcount_r <= cfg_data;
  end

  ucd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .last_edge(in_data.last_edge),
    .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_valid)
  );

  ucd_dpath #(.MAX_EDGES(MAX_EDGES)) u_dpath (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .vcount(vcount_r),
    .cmd(cmd), .sts(sts), .result(res)
  );

  assign out_data = res;

endmodule
`default_nettype wire

// File: hdl/ucd_checker.sv
// Checker: port-level properties of the cycle detector, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module ucd_port_props (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");

  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  a_busy_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> busy) else $error("idle right after result");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("not idle after reset");

endmodule

bind undirected_cycle_detect_top ucd_port_props u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);
`default_nettype wire
